/* src/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, an active-low reset, a trigger and a condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* src/srec_pkg.sv */
// Types and constants for the S-record S3/S7 loader.
// No dependencies; used by the loader top level and its checker.
`default_nettype none

package srec_pkg;

  // Record parser phase
  typedef enum logic [3:0] {
    PH_WAIT_S   = 4'd0,
    PH_TYPE     = 4'd1,
    PH_S3_LEN   = 4'd2,
    PH_S3_ADDR0 = 4'd3,
    PH_S3_ADDR1 = 4'd4,
    PH_S3_ADDR2 = 4'd5,
    PH_S3_ADDR3 = 4'd6,
    PH_S3_DATA  = 4'd7,
    PH_S3_SUM   = 4'd8,
    PH_S7_LEN   = 4'd9,
    PH_S7_ADDR0 = 4'd10,
    PH_S7_ADDR1 = 4'd11,
    PH_S7_ADDR2 = 4'd12,
    PH_S7_ADDR3 = 4'd13,
    PH_S7_SUM   = 4'd14
  } phase_e;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_RUN   = 3'd1,
    KIND_FLASH = 3'd2,
    KIND_FATAL = 3'd3,
    KIND_WARN  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_SYNC    = 3'd0,
    ERR_S3_LEN  = 3'd1,
    ERR_RANGE   = 3'd2,
    ERR_CSUM    = 3'd3,
    ERR_S7_LEN  = 3'd4,
    ERR_S7_ADDR = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    CFG_WIN_START = 2'd0,
    CFG_WIN_END   = 2'd1,
    CFG_ROM_BASE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [31:0] target_address;
    logic [7:0]  write_data;
    logic [31:0] flash_length;
    err_e        error_code;
    logic        last_in_run;
  } out_item_t;

  // Characters
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_3  = 8'h33;
  localparam logic [7:0] CHAR_7  = 8'h37;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Record rules
  localparam logic [7:0] SUM_OK      = 8'hFF;
  localparam logic [7:0] S3_MIN_LEN  = 8'd5;
  localparam logic [7:0] S7_LEN_VAL  = 8'd5;
  localparam logic [31:0] S7_END_GAP = 32'd2;

  // Register reset values
  localparam logic [31:0] WIN_START_RST = 32'h0060_0000;
  localparam logic [31:0] WIN_END_RST   = 32'h0080_0000;
  localparam logic [31:0] ROM_BASE_RST  = 32'h4000_0000;

  // Result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

endpackage

`default_nettype wire

/* src/srecord_s3_loader_unit.sv */
// Motorola S-record loader for S3 data records and one S7 end record.
// Depends on srec_pkg for payload types, codes and constants.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries one word per received
//   character, or a start word (req_type = 1) that clears the parser state.
//   Output channel (out_valid_o/out_ready_i/out_item_o) carries byte writes, the
//   run or flash request, fatal errors and bad-digit warnings, with last_in_run
//   marking the final result of each input word.
//   Config channel (cfg_valid_i/cfg_ready_o), always ready, writes window_start,
//   window_end, rom_base; the user writes only while the block is idle, unenforced.
// Pipeline: an accepted word waits in the input register until the result queue has
//   room, is then parsed, and its results are written to the queue before the output.
// Throughput: one input word per cycle while the result queue has room. The parse
//   stage writes up to two results per word into a four-entry result queue; input
//   ready drops while a word waits in the input register and the queue has fewer
//   than two free entries.
// Reset: parser state cleared, registers at their defaults, queue empty.
// Output stall: results wait in the queue; the parse stage then the input
//   register hold, and in_ready_o falls.
`default_nettype none

module srecord_s3_loader_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire srec_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output srec_pkg::out_item_t     out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  // Configuration registers
  logic [31:0] win_start_q, win_end_q, rom_base_q, delta_q;

  // Input register
  logic               item_vld_q;
  srec_pkg::in_item_t item_q;

  // Parser state
  srec_pkg::phase_e phase_q, phase_d;
  logic        stop_q, stop_d;
  logic        hi_q, hi_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] off_q, off_d;
  logic [31:0] low_q, low_d;
  logic [31:0] high_q, high_d;

  // Result queue
  srec_pkg::out_item_t             res_mem_q [srec_pkg::RES_DEPTH];
  logic [srec_pkg::RES_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [srec_pkg::RES_CNT_W-1:0]  cnt_q, cnt_d;

  // Datapath signals
  logic        room, go, start, active, hexph, take, pop;
  logic [7:0]  c;
  logic        is_hex;
  logic [3:0]  nib;
  logic [7:0]  b, sum_new, left_m1;
  logic [31:0] ab, a0, a, inc;
  logic        first, reloc, win_ok;
  logic        fail;
  srec_pkg::err_e      fail_code;
  logic                warn_fire, main_fire;
  srec_pkg::out_item_t warn_item, main_item;
  logic [1:0]          push_n;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign room        = (cnt_q <= srec_pkg::RES_CNT_W'(srec_pkg::RES_DEPTH - 2));
  assign go          = item_vld_q && room;
  assign in_ready_o  = !item_vld_q || room;
  assign start       = item_q.req_type;
  assign active      = go && !start && !stop_q;
  assign c           = item_q.char_code;
  assign hexph       = (phase_q != srec_pkg::PH_WAIT_S) && (phase_q != srec_pkg::PH_TYPE);
  assign take        = hexph && hi_q;

  // Configuration writes and relocation delta
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= srec_pkg::WIN_START_RST;
      win_end_q   <= srec_pkg::WIN_END_RST;
      rom_base_q  <= srec_pkg::ROM_BASE_RST;
      delta_q     <= srec_pkg::ROM_BASE_RST - srec_pkg::WIN_START_RST;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          srec_pkg::CFG_WIN_START: win_start_q <= cfg_data_i;
          srec_pkg::CFG_WIN_END:   win_end_q   <= cfg_data_i;
          srec_pkg::CFG_ROM_BASE:  rom_base_q  <= cfg_data_i;
          default: ;
        endcase
      end
      delta_q <= rom_base_q - win_start_q;
    end
  end

  // Input register: hold the word until the parse stage takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_vld_q <= 1'b1;
    end else if (go) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  // Hex digit decode; a bad digit counts as zero
  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      nib = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Byte assembly, checksum and address arithmetic
  assign b       = byte_q | {4'b0, nib};
  assign sum_new = sum_q + b;
  assign left_m1 = left_q - 8'd1;
  assign ab      = {addr_q[23:0], b};
  assign a0      = ab - off_q;
  assign first   = (low_q == 32'd0);
  assign reloc   = first && (a0 >= rom_base_q);
  assign a       = reloc ? (a0 - delta_q) : a0;
  assign win_ok  = (a >= win_start_q) && (a < win_end_q);
  assign inc     = addr_q + 32'd1;

  // Fatal error decision
  always_comb begin
    fail      = 1'b0;
    fail_code = srec_pkg::ERR_SYNC;
    unique case (phase_q) inside
      srec_pkg::PH_WAIT_S: begin
        fail = (c != srec_pkg::CHAR_S) && (c != srec_pkg::CHAR_CR) &&
               (c != srec_pkg::CHAR_LF);
      end
      srec_pkg::PH_TYPE: begin
        fail = (c != srec_pkg::CHAR_3) && (c != srec_pkg::CHAR_7);
      end
      srec_pkg::PH_S3_LEN: begin
        fail      = take && (b < srec_pkg::S3_MIN_LEN);
        fail_code = srec_pkg::ERR_S3_LEN;
      end
      srec_pkg::PH_S3_ADDR3: begin
        fail      = take && !win_ok;
        fail_code = srec_pkg::ERR_RANGE;
      end
      srec_pkg::PH_S3_SUM: begin
        fail      = take && (sum_new != srec_pkg::SUM_OK);
        fail_code = srec_pkg::ERR_CSUM;
      end
      srec_pkg::PH_S7_LEN: begin
        fail      = take && (b != srec_pkg::S7_LEN_VAL);
        fail_code = srec_pkg::ERR_S7_LEN;
      end
      srec_pkg::PH_S7_SUM: begin
        fail      = take && (off_q == 32'd0) &&
                    ((addr_q < low_q) || (addr_q >= high_q - srec_pkg::S7_END_GAP));
        fail_code = srec_pkg::ERR_S7_ADDR;
      end
      srec_pkg::PH_S3_ADDR0, srec_pkg::PH_S3_ADDR1, srec_pkg::PH_S3_ADDR2,
      srec_pkg::PH_S3_DATA, srec_pkg::PH_S7_ADDR0, srec_pkg::PH_S7_ADDR1,
      srec_pkg::PH_S7_ADDR2, srec_pkg::PH_S7_ADDR3: begin
        fail = 1'b0;
      end
      default: begin
        fail = take;
      end
    endcase
  end

  // Next phase and stop flag
  always_comb begin
    phase_d = phase_q;
    stop_d  = stop_q;
    if (go && start) begin
      phase_d = srec_pkg::PH_WAIT_S;
      stop_d  = 1'b0;
    end else if (active) begin
      if (fail) begin
        stop_d = 1'b1;
      end else begin
        unique case (phase_q) inside
          srec_pkg::PH_WAIT_S: begin
            if (c == srec_pkg::CHAR_S) phase_d = srec_pkg::PH_TYPE;
          end
          srec_pkg::PH_TYPE: begin
            phase_d = (c == srec_pkg::CHAR_3) ? srec_pkg::PH_S3_LEN : srec_pkg::PH_S7_LEN;
          end
          srec_pkg::PH_S3_LEN, srec_pkg::PH_S3_ADDR0, srec_pkg::PH_S3_ADDR1,
          srec_pkg::PH_S3_ADDR2, srec_pkg::PH_S7_LEN, srec_pkg::PH_S7_ADDR0,
          srec_pkg::PH_S7_ADDR1, srec_pkg::PH_S7_ADDR2, srec_pkg::PH_S7_ADDR3: begin
            if (take) phase_d = srec_pkg::phase_e'(phase_q + 4'd1);
          end
          srec_pkg::PH_S3_ADDR3: begin
            if (take) begin
              phase_d = (left_q == 8'd0) ? srec_pkg::PH_S3_SUM : srec_pkg::PH_S3_DATA;
            end
          end
          srec_pkg::PH_S3_DATA: begin
            if (take && left_m1 == 8'd0) phase_d = srec_pkg::PH_S3_SUM;
          end
          srec_pkg::PH_S3_SUM: begin
            if (take) phase_d = srec_pkg::PH_WAIT_S;
          end
          srec_pkg::PH_S7_SUM: begin
            if (take) stop_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Parser datapath and results
  always_comb begin
    hi_d   = hi_q;
    byte_d = byte_q;
    left_d = left_q;
    sum_d  = sum_q;
    addr_d = addr_q;
    off_d  = off_q;
    low_d  = low_q;
    high_d = high_q;

    warn_fire = active && hexph && !is_hex;
    warn_item = '{result_kind: srec_pkg::KIND_WARN, target_address: 32'd0,
                  write_data: 8'd0, flash_length: 32'd0,
                  error_code: srec_pkg::ERR_SYNC, last_in_run: 1'b1};
    main_fire = 1'b0;
    main_item = '{result_kind: srec_pkg::KIND_FATAL, target_address: 32'd0,
                  write_data: 8'd0, flash_length: 32'd0,
                  error_code: fail_code, last_in_run: 1'b1};

    if (go && start) begin
      hi_d   = 1'b0;
      byte_d = 8'd0;
      left_d = 8'd0;
      sum_d  = 8'd0;
      addr_d = 32'd0;
      off_d  = 32'd0;
      low_d  = 32'd0;
      high_d = 32'd0;
    end else if (active) begin
      if (phase_q == srec_pkg::PH_WAIT_S) begin
        if (c == srec_pkg::CHAR_S) sum_d = 8'd0;
      end else if (phase_q == srec_pkg::PH_TYPE) begin
        hi_d = 1'b0;
      end else if (!hi_q) begin
        byte_d = {nib, 4'b0};
        hi_d   = 1'b1;
      end else begin
        byte_d = b;
        hi_d   = 1'b0;
        sum_d  = sum_new;
        unique case (phase_q) inside
          srec_pkg::PH_S3_LEN: begin
            if (!fail) begin
              left_d = b - srec_pkg::S3_MIN_LEN;
              addr_d = 32'd0;
            end
          end
          srec_pkg::PH_S3_ADDR0, srec_pkg::PH_S3_ADDR1, srec_pkg::PH_S3_ADDR2,
          srec_pkg::PH_S7_ADDR0, srec_pkg::PH_S7_ADDR1, srec_pkg::PH_S7_ADDR2,
          srec_pkg::PH_S7_ADDR3: begin
            addr_d = ab;
          end
          srec_pkg::PH_S3_ADDR3: begin
            // Relocation is decided on each record while low_q is still zero, as on the first
            addr_d = ab;
            if (first) begin
              low_d = a;
              if (reloc) off_d = delta_q;
            end
            if (win_ok) begin
              addr_d = a;
              if (left_q == 8'd0 && a > high_q) high_d = a;
            end
          end
          srec_pkg::PH_S3_DATA: begin
            main_fire = 1'b1;
            main_item.result_kind    = srec_pkg::KIND_WRITE;
            main_item.target_address = addr_q;
            main_item.write_data     = b;
            addr_d = inc;
            left_d = left_m1;
            if (left_m1 == 8'd0 && inc > high_q) high_d = inc;
          end
          srec_pkg::PH_S7_LEN: begin
            if (!fail) addr_d = 32'd0;
          end
          srec_pkg::PH_S7_SUM: begin
            if (!fail) begin
              main_fire = 1'b1;
              if (off_q == 32'd0) begin
                main_item.result_kind    = srec_pkg::KIND_RUN;
                main_item.target_address = addr_q;
              end else begin
                main_item.result_kind    = srec_pkg::KIND_FLASH;
                main_item.target_address = win_start_q;
                main_item.flash_length   = high_q - low_q;
              end
            end
          end
          default: ;
        endcase
      end
      if (fail) main_fire = 1'b1;
      if (main_item.result_kind != srec_pkg::KIND_FATAL) begin
        main_item.error_code = srec_pkg::ERR_SYNC;
      end
      warn_item.last_in_run = !main_fire;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= srec_pkg::PH_WAIT_S;
      stop_q  <= 1'b0;
      hi_q    <= 1'b0;
      byte_q  <= 8'd0;
      left_q  <= 8'd0;
      sum_q   <= 8'd0;
      addr_q  <= 32'd0;
      off_q   <= 32'd0;
      low_q   <= 32'd0;
      high_q  <= 32'd0;
    end else begin
      phase_q <= phase_d;
      stop_q  <= stop_d;
      hi_q    <= hi_d;
      byte_q  <= byte_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      addr_q  <= addr_d;
      off_q   <= off_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // Result queue: push up to two words, pop one
  assign pop    = out_valid_o && out_ready_i;
  assign push_n = {1'b0, warn_fire} + {1'b0, main_fire};
  assign cnt_d  = cnt_q + srec_pkg::RES_CNT_W'(push_n) - srec_pkg::RES_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + srec_pkg::RES_PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + srec_pkg::RES_PTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (warn_fire) begin
      res_mem_q[wr_ptr_q] <= warn_item;
    end
    if (main_fire) begin
      res_mem_q[warn_fire ? wr_ptr_q + srec_pkg::RES_PTR_W'(1) : wr_ptr_q] <= main_item;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = res_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

/* src/srec_checker.sv */
// Port-level checks for the S-record loader, bound to its top level.
// Depends on srec_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srec_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire srec_pkg::out_item_t out_item_o
);

  logic is_fatal, is_warn, is_write, done;

  assign is_fatal = out_item_o.result_kind == srec_pkg::KIND_FATAL;
  assign is_warn  = out_item_o.result_kind == srec_pkg::KIND_WARN;
  assign is_write = out_item_o.result_kind == srec_pkg::KIND_WRITE;
  assign done     = out_valid_o && out_ready_i;

  // Hold a stalled result word
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // A fatal error closes the results of its input word
  `ASSERT_SAME(a_fatal_last, clk_i, rst_ni, out_valid_o && is_fatal, out_item_o.last_in_run)

  // Only a warning can be followed by another result of the same word
  `ASSERT_SAME(a_nonlast_warn, clk_i, rst_ni, out_valid_o && !out_item_o.last_in_run, is_warn)

  // The partner of a warning is queued with it, and is never a second warning
  `ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, done && !out_item_o.last_in_run, out_valid_o && !is_warn)

  // Only byte writes carry data
  `ASSERT_SAME(a_data_zero, clk_i, rst_ni, out_valid_o && !is_write, out_item_o.write_data == 8'd0)

endmodule

bind srecord_s3_loader_unit srec_checker u_srec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

/* dv/srecord_s3_loader_unit_test.sv */
`timescale 1ns / 100ps
// Testbench for srecord_s3_loader_unit: feeds S3/S7 record streams, line noise and
// register settings, and checks each result word against a parser model kept here.
// Depends on srec_pkg (src/srec_pkg.sv) and the loader RTL.

module srecord_s3_loader_unit_test;
  import srec_pkg::*;

  localparam int WORDS_TOTAL  = 1150;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam err_e NO_ERR     = ERR_SYNC;

  localparam logic [7:0] ASCII_0    = 8'h30;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_UC_A = 8'h41;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_e    cfg_index;
  logic [31:0] cfg_data;

  // Parser model state and register shadows
  phase_e      ld_phase;
  logic        nib_pending;
  logic [7:0]  byte_acc;
  logic [7:0]  bytes_left;
  logic [7:0]  sum_acc;
  logic [31:0] addr_acc;
  logic [31:0] reloc_off;
  logic [31:0] low_addr;
  logic [31:0] high_addr;
  logic        halted;
  logic [31:0] win_start;
  logic [31:0] win_end;
  logic [31:0] rom_base_r;

  out_item_t   word_results[$];
  out_item_t   results_due[$];
  logic [7:0]  record_data[$];
  int          mismatches;
  int          words_sent;
  int          idle_cycles;
  bit          idle_on;
  bit          digit_noise;

  srecord_s3_loader_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // Return {valid, nibble} for one character
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    if (c >= ASCII_0 && c <= ASCII_0 + 8'd9) return {1'b1, 4'(c - ASCII_0)};
    if (c >= ASCII_LC_A && c <= ASCII_LC_A + 8'd5) return {1'b1, 4'(c - ASCII_LC_A + 8'd10)};
    if (c >= ASCII_UC_A && c <= ASCII_UC_A + 8'd5) return {1'b1, 4'(c - ASCII_UC_A + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void clear_parser();
    ld_phase    = PH_WAIT_S;
    nib_pending = 1'b0;
    byte_acc    = '0;
    bytes_left  = '0;
    sum_acc     = '0;
    addr_acc    = '0;
    reloc_off   = '0;
    low_addr    = '0;
    high_addr   = '0;
    halted      = 1'b0;
  endfunction

  function automatic void add_result(kind_e k, logic [31:0] a, logic [7:0] d,
                                     logic [31:0] len, err_e e);
    word_results.push_back('{result_kind: k, target_address: a, write_data: d,
                             flash_length: len, error_code: e, last_in_run: 1'b0});
  endfunction

  function automatic void stop_on(err_e e);
    add_result(KIND_FATAL, '0, '0, '0, e);
    halted = 1'b1;
  endfunction

  function automatic void note_highest();
    if (addr_acc > high_addr) high_addr = addr_acc;
  endfunction

  // Advance the record parser by one assembled byte
  function automatic void take_byte(logic [7:0] b);
    logic [31:0] a;
    case (ld_phase)
      PH_S3_LEN: begin
        if (b < S3_MIN_LEN) stop_on(ERR_S3_LEN);
        else begin
          bytes_left = b - S3_MIN_LEN;
          addr_acc   = '0;
          ld_phase   = PH_S3_ADDR0;
        end
      end
      PH_S3_ADDR0, PH_S3_ADDR1, PH_S3_ADDR2,
      PH_S7_ADDR0, PH_S7_ADDR1, PH_S7_ADDR2, PH_S7_ADDR3: begin
        addr_acc = {addr_acc[23:0], b};
        ld_phase = phase_e'(ld_phase + 4'd1);
      end
      PH_S3_ADDR3: begin
        a = {addr_acc[23:0], b} - reloc_off;
        // while low_addr is still zero, the record decides relocation and sets the lowest address
        if (low_addr == '0) begin
          if (a >= rom_base_r) begin
            reloc_off = rom_base_r - win_start;
            a = a - reloc_off;
          end
          low_addr = a;
        end
        if (a < win_start || a >= win_end) stop_on(ERR_RANGE);
        else begin
          addr_acc = a;
          if (bytes_left == '0) begin
            note_highest();
            ld_phase = PH_S3_SUM;
          end else ld_phase = PH_S3_DATA;
        end
      end
      PH_S3_DATA: begin
        add_result(KIND_WRITE, addr_acc, b, '0, NO_ERR);
        addr_acc   = addr_acc + 32'd1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == '0) begin
          note_highest();
          ld_phase = PH_S3_SUM;
        end
      end
      PH_S3_SUM: begin
        if (sum_acc != SUM_OK) stop_on(ERR_CSUM);
        else ld_phase = PH_WAIT_S;
      end
      PH_S7_LEN: begin
        if (b != S7_LEN_VAL) stop_on(ERR_S7_LEN);
        else begin
          addr_acc = '0;
          ld_phase = PH_S7_ADDR0;
        end
      end
      PH_S7_SUM: begin
        // checksum is summed but not checked; the load ends here
        if (reloc_off != '0) add_result(KIND_FLASH, win_start, '0, high_addr - low_addr, NO_ERR);
        else if (addr_acc < low_addr || addr_acc >= high_addr - S7_END_GAP) stop_on(ERR_S7_ADDR);
        else add_result(KIND_RUN, addr_acc, '0, '0, NO_ERR);
        halted = 1'b1;
      end
      default: stop_on(ERR_SYNC);
    endcase
  endfunction

  // Work out the results of one accepted word and queue them
  function automatic void predict_loader_results(in_item_t w);
    logic [4:0] hx;
    logic [7:0] b;
    word_results.delete();
    if (w.req_type) begin
      clear_parser();
    end else if (!halted) begin
      case (ld_phase)
        PH_WAIT_S: begin
          if (w.char_code == CHAR_S) begin
            sum_acc  = '0;
            ld_phase = PH_TYPE;
          end else if (w.char_code != CHAR_CR && w.char_code != CHAR_LF) stop_on(ERR_SYNC);
        end
        PH_TYPE: begin
          nib_pending = 1'b0;
          if (w.char_code == CHAR_3) ld_phase = PH_S3_LEN;
          else if (w.char_code == CHAR_7) ld_phase = PH_S7_LEN;
          else stop_on(ERR_SYNC);
        end
        default: begin
          hx = hex_decode(w.char_code);
          // a bad digit warns and counts as zero
          if (!hx[4]) add_result(KIND_WARN, '0, '0, '0, NO_ERR);
          if (!nib_pending) begin
            byte_acc    = {hx[3:0], 4'h0};
            nib_pending = 1'b1;
          end else begin
            b           = byte_acc | {4'h0, hx[3:0]};
            byte_acc    = b;
            nib_pending = 1'b0;
            sum_acc     = sum_acc + b;
            take_byte(b);
          end
        end
      endcase
    end
    if (word_results.size() > 0) word_results[word_results.size() - 1].last_in_run = 1'b1;
    foreach (word_results[i]) results_due.push_back(word_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result word with the oldest one due
  always @(posedge clk) begin : check_results
    out_item_t due;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d addr %h data %h",
                 $time, out_word.result_kind, out_word.target_address, out_word.write_data);
        mismatches++;
      end else begin
        due = results_due.pop_front();
        check_field("result_kind", due.result_kind, out_word.result_kind);
        check_field("target_address", due.target_address, out_word.target_address);
        check_field("write_data", due.write_data, out_word.write_data);
        check_field("flash_length", due.flash_length, out_word.flash_length);
        check_field("error_code", due.error_code, out_word.error_code);
        check_field("last_in_run", due.last_in_run, out_word.last_in_run);
      end
    end
  end

  // Count cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Receiver stalls in random bursts
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then predict its results
  task automatic send_word(in_item_t w);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    predict_loader_results(w);
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] c);
    send_word('{req_type: 1'b0, char_code: c});
  endtask

  task automatic send_start();
    send_word('{req_type: 1'b1, char_code: 8'($urandom)});
  endtask

  // Send a byte as two hex digits in random case, now and then with a bad digit
  task automatic send_hex(logic [7:0] b);
    logic [3:0] nib;
    logic [7:0] c;
    logic [4:0] hx;
    for (int i = 1; i >= 0; i--) begin
      nib = b[4*i +: 4];
      if (nib < 4'd10) c = ASCII_0 + nib;
      else if ($urandom_range(0, 1) == 1) c = ASCII_LC_A + nib - 8'd10;
      else c = ASCII_UC_A + nib - 8'd10;
      if (digit_noise && $urandom_range(0, 199) == 0) begin
        do begin
          c  = 8'($urandom);
          hx = hex_decode(c);
        end while (hx[4]);
      end
      send_char(c);
    end
  endtask

  task automatic send_addr(logic [31:0] a);
    for (int i = 3; i >= 0; i--) send_hex(a[8*i +: 8]);
  endtask

  // S3 record carrying record_data; sum_skew nonzero breaks the checksum
  task automatic send_s3(logic [31:0] a, logic [7:0] sum_skew);
    logic [7:0] len;
    logic [7:0] sum;
    len = 8'(record_data.size() + 5);
    sum = len + a[31:24] + a[23:16] + a[15:8] + a[7:0];
    send_char(CHAR_S);
    send_char(CHAR_3);
    send_hex(len);
    send_addr(a);
    foreach (record_data[i]) begin
      send_hex(record_data[i]);
      sum = sum + record_data[i];
    end
    send_hex(~sum + sum_skew);
  endtask

  task automatic send_s7(logic [31:0] a, logic [7:0] sum_skew);
    logic [7:0] sum;
    sum = S7_LEN_VAL + a[31:24] + a[23:16] + a[15:8] + a[7:0];
    send_char(CHAR_S);
    send_char(CHAR_7);
    send_hex(S7_LEN_VAL);
    send_addr(a);
    send_hex(~sum + sum_skew);
  endtask

  task automatic end_line();
    case ($urandom_range(0, 3))
      1: send_char(CHAR_CR);
      2: send_char(CHAR_LF);
      3: begin
        send_char(CHAR_CR);
        send_char(CHAR_LF);
      end
      default: ;
    endcase
  endtask

  // Drop valid, let every due result arrive, then let the pipeline settle
  task automatic wait_drain();
    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIN_START: win_start  = value;
      CFG_WIN_END:   win_end    = value;
      CFG_ROM_BASE:  rom_base_r = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_window(logic [31:0] ws, logic [31:0] we, logic [31:0] rb);
    wait_drain();
    write_register(CFG_WIN_START, ws);
    write_register(CFG_WIN_END, we);
    write_register(CFG_ROM_BASE, rb);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain RAM load ending in a run request; later characters are ignored
  task automatic test_run_load();
    send_start();
    record_data = '{8'h00, 8'hFF, 8'h5A};
    send_s3(WIN_START_RST, 8'h00);
    send_char(CHAR_CR);
    send_char(CHAR_LF);
    record_data.delete();
    send_s3(WIN_START_RST + 32'd3, 8'h00);
    send_s7(WIN_START_RST, 8'h00);
    send_char(CHAR_S);
    send_char(8'h58);
  endtask

  // ROM image relocated into the window, ending in a flash request
  task automatic test_flash_load();
    send_start();
    record_data = '{8'h12, 8'h34};
    send_s3(ROM_BASE_RST + 32'h10, 8'h00);
    record_data = '{8'hAB};
    send_s3(ROM_BASE_RST + 32'h12, 8'h00);
    send_s7(32'h0, 8'h00);
  endtask

  // Bad digits inside a record, one character giving a warning and a write
  task automatic test_bad_digits();
    send_start();
    send_char(CHAR_S);
    send_char(CHAR_3);
    send_hex(8'h06);
    send_addr(WIN_START_RST + 32'h100);
    send_char(8'h67);
    send_char(CHAR_CR);
    send_hex(8'h98);
    send_char(CHAR_LF);
    send_char(CHAR_S);
    send_char(CHAR_7);
    send_hex(8'h04);
  endtask

  // Fatal errors other than the S7 length error, each from a fresh start
  task automatic test_fatal_errors();
    send_start();
    send_char(8'h58);
    send_start();
    send_char(CHAR_S);
    send_char(8'h34);
    send_start();
    send_char(CHAR_S);
    send_char(CHAR_3);
    send_hex(8'h04);
    send_start();
    record_data = '{8'h01};
    send_s3(WIN_END_RST, 8'h00);
    send_start();
    send_s3(WIN_START_RST, 8'h01);
    send_start();
    record_data = '{8'h01, 8'h02, 8'h03};
    send_s3(WIN_START_RST + 32'h10, 8'h00);
    send_s7(WIN_START_RST + 32'h11, 8'h00);
    send_start();
    send_s3(WIN_START_RST + 32'h10, 8'h00);
    send_s7(WIN_START_RST + 32'h0F, 8'h00);
  endtask

  // Window and ROM base at their limits, address wrap, zero first address
  task automatic test_register_extremes();
    set_window(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_start();
    record_data = '{8'hC3, 8'h3C, 8'hFF};
    send_s3(32'hFFFF_FFFE, 8'h00);
    send_s7(32'hFFFF_FFFE, 8'h00);
    send_start();
    record_data = '{8'h11};
    send_s3(32'h0, 8'h00);
    send_s3(32'hFFFF_FFFF, 8'h00);
    send_s7(32'h0, 8'h00);

    set_window(32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0);
    send_start();
    record_data = '{8'h80};
    send_s3(32'h10, 8'h00);
    send_s7(32'h10, 8'h00);

    set_window(32'h0, 32'h0, 32'h0);
    send_start();
    send_s3(32'h1234, 8'h00);

    set_window(WIN_START_RST, WIN_END_RST, ROM_BASE_RST);
  endtask

  // One load: start, a few S3 records with random content, S7 at the end
  task automatic random_load();
    logic [31:0] span;
    logic [31:0] first;
    logic [31:0] next;
    // now and then skip the start so a stopped parser sees the load
    if ($urandom_range(0, 15) != 0) send_start();
    span = win_end - win_start;
    if (span > 32'd4096) span = 32'd4096;
    first = win_start + $urandom_range(0, span - 32);
    if ($urandom_range(0, 2) == 0) first = first - win_start + rom_base_r;
    next = first;
    repeat ($urandom_range(1, 4)) begin
      record_data.delete();
      repeat ($urandom_range(0, 8)) record_data.push_back(8'($urandom));
      send_s3(next, ($urandom_range(0, 24) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      next = next + record_data.size() + $urandom_range(0, 2);
      if ($urandom_range(0, 29) == 0) send_char(8'($urandom));
      end_line();
    end
    send_s7(($urandom_range(0, 4) == 0) ? 32'($urandom) : first + $urandom_range(0, 2),
            8'($urandom_range(0, 1)));
  endtask

  // Random loads over several register settings until the word budget is used;
  // the last phase runs without idling
  task automatic test_random_loads();
    logic [31:0] ws;
    logic [31:0] span;
    int goal;
    int base;
    digit_noise = 1'b1;
    base = words_sent;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        ws   = $urandom & 32'h7FFF_FFFF;
        span = $urandom_range(64, 4096);
        set_window(ws, ws + span, ws + span + ($urandom & 32'h0FFF_FFFF));
      end
      idle_on = (ph == 0 || ph == 2);
      goal = base + (WORDS_TOTAL - base) * (ph + 1) / 4;
      while (words_sent < goal) random_load();
    end
    idle_on = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_WIN_START;
    cfg_data    = '0;
    idle_on     = 1'b0;
    digit_noise = 1'b0;
    win_start   = WIN_START_RST;
    win_end     = WIN_END_RST;
    rom_base_r  = ROM_BASE_RST;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_on = 1'b1;
    test_run_load();
    test_flash_load();
    test_bad_digits();
    test_fatal_errors();
    test_register_extremes();
    test_random_loads();
    wait_drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* srecord_s3_loader_unit.f */
+incdir+src
src/srec_pkg.sv
src/srecord_s3_loader_unit.sv
src/srec_checker.sv
dv/srecord_s3_loader_unit_test.sv
